### rtl/linear_probe_hash_table_defines.svh
// Assertion macros used by the hash table checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lpht_pkg.sv
// Shared types, constants and codes of the linear probing hash table.
// No dependencies.
package lpht_pkg;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned HEAD_W      = 64;
  localparam int unsigned TAIL_W      = 8;
  localparam int unsigned KEY_W       = HEAD_W + TAIL_W;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned IDX_OUT_W   = 3;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned SUM_W       = 9;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam int unsigned MUL_W       = 2 * SUM_W;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / SLOTS;

  localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(SLOTS - 1);
  localparam logic [SUM_W-1:0]  SLOTS_V   = SUM_W'(SLOTS);
  localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [CODE_W-1:0] RC_INSERTED  = 3'd0;
  localparam logic [CODE_W-1:0] RC_FULL      = 3'd1;
  localparam logic [CODE_W-1:0] RC_REMOVED   = 3'd2;
  localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd3;
  localparam logic [CODE_W-1:0] RC_FOUND     = 3'd4;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_REMOVED  = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'b001,
    FSM_HASH  = 3'b010,
    FSM_PROBE = 3'b100
  } fsm_e;

  typedef struct packed {
    logic load;
    logic hash;
    logic advance;
    logic finish;
  } lpht_cmd_t;

  typedef struct packed {
    logic done;
  } lpht_sts_t;

endpackage

### rtl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/lpht_ctrl.sv
// Sequencer of the hash table: accept, hash, probe, hand off the result.
// Depends on lpht_pkg.
module lpht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lpht_pkg::lpht_cmd_t cmd_o,
  input  lpht_pkg::lpht_sts_t sts_i
);

  lpht_pkg::fsm_e state_q, state_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == lpht_pkg::FSM_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lpht_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lpht_pkg::FSM_HASH;
        end
      end
      lpht_pkg::FSM_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = lpht_pkg::FSM_PROBE;
      end
      lpht_pkg::FSM_PROBE: begin
        if (!sts_i.done) begin
          cmd_o.advance = 1'b1;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = lpht_pkg::FSM_IDLE;
        end
      end
      default: state_d = lpht_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/lpht_dp.sv
// Datapath of the hash table: request registers, home slot, slot status,
// key RAM, probe index and result register. Depends on lpht_pkg, lpht_ram.
module lpht_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lpht_pkg::lpht_cmd_t               cmd_i,
  output lpht_pkg::lpht_sts_t               sts_o,
  input  logic [lpht_pkg::REQ_W-1:0]        req_type_i,
  input  logic [lpht_pkg::HEAD_W-1:0]       key_head_i,
  input  logic [lpht_pkg::TAIL_W-1:0]       key_tail_i,
  output logic [lpht_pkg::CODE_W-1:0]       result_code_o,
  output logic [lpht_pkg::IDX_OUT_W-1:0]    slot_index_o
);

  logic [lpht_pkg::REQ_W-1:0]     req_q;
  logic [lpht_pkg::HEAD_W-1:0]    head_q;
  logic [lpht_pkg::TAIL_W-1:0]    tail_q;
  logic [lpht_pkg::SUM_W-1:0]     sum_q;
  logic [lpht_pkg::SUM_W-1:0]     sum_in;
  logic [lpht_pkg::PROD_W-1:0]    prod_q;
  logic [lpht_pkg::SLOT_W-1:0]    idx_q, idx_d, idx_next;
  logic [lpht_pkg::SLOT_W-1:0]    cnt_q, cnt_d;
  logic [lpht_pkg::SLOT_W-1:0]    home;
  logic [lpht_pkg::SUM_W-1:0]     quot;
  logic [lpht_pkg::MUL_W-1:0]     rem_wide;
  logic [lpht_pkg::SUM_W-1:0]     rem;
  logic [lpht_pkg::KEY_W-1:0]     rdata;
  logic [lpht_pkg::SLOT_W+lpht_pkg::IDX_OUT_W-1:0] idx_ext;
  logic [lpht_pkg::IDX_OUT_W-1:0] slot3;
  lpht_pkg::slot_st_e             status_q [lpht_pkg::SLOTS];
  lpht_pkg::slot_st_e             st;
  logic                           key_hit, last, done;
  logic                           do_write, do_remove;
  logic [lpht_pkg::CODE_W-1:0]    code;
  logic [lpht_pkg::IDX_OUT_W-1:0] slot;
  logic [lpht_pkg::CODE_W-1:0]    code_q;
  logic [lpht_pkg::IDX_OUT_W-1:0] slot_q;

  assign sum_in = lpht_pkg::SUM_W'(key_head_i[7:0]) + lpht_pkg::SUM_W'(key_head_i[15:8]);

  // reciprocal quotient estimate is low by at most one
  always_comb begin
    quot     = prod_q[lpht_pkg::RECIP_SHIFT +: lpht_pkg::SUM_W];
    rem_wide = lpht_pkg::MUL_W'(sum_q)
             - lpht_pkg::MUL_W'(quot) * lpht_pkg::MUL_W'(lpht_pkg::SLOTS_V);
    rem      = rem_wide[lpht_pkg::SUM_W-1:0];
    if (rem >= lpht_pkg::SLOTS_V) begin
      rem = rem - lpht_pkg::SLOTS_V;
    end
    home = rem[lpht_pkg::SLOT_W-1:0];
  end

  assign idx_next = (idx_q == lpht_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;

  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (cmd_i.hash) begin
      idx_d = home;
      cnt_d = '0;
    end else if (cmd_i.advance) begin
      idx_d = idx_next;
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign idx_ext = {{lpht_pkg::IDX_OUT_W{1'b0}}, idx_q};
  assign slot3   = idx_ext[lpht_pkg::IDX_OUT_W-1:0];
  assign st      = status_q[idx_q];
  assign key_hit = (rdata == {tail_q, head_q});
  assign last    = (cnt_q == lpht_pkg::LAST_IDX);

  always_comb begin
    done      = 1'b1;
    do_write  = 1'b0;
    do_remove = 1'b0;
    code      = lpht_pkg::RC_NOT_FOUND;
    slot      = '0;
    unique case (req_q) inside
      lpht_pkg::REQ_INSERT: begin
        if (st != lpht_pkg::ST_OCCUPIED) begin
          do_write = 1'b1;
          code     = lpht_pkg::RC_INSERTED;
          slot     = slot3;
        end else begin
          done = last;
          code = lpht_pkg::RC_FULL;
        end
      end
      lpht_pkg::REQ_REMOVE, lpht_pkg::REQ_LOOKUP: begin
        if (st == lpht_pkg::ST_OCCUPIED && key_hit) begin
          slot = slot3;
          if (req_q == lpht_pkg::REQ_REMOVE) begin
            do_remove = 1'b1;
            code      = lpht_pkg::RC_REMOVED;
          end else begin
            code = lpht_pkg::RC_FOUND;
          end
        end else begin
          done = (st == lpht_pkg::ST_FREE) || last;
        end
      end
      default: done = 1'b1;
    endcase
  end

  assign sts_o.done = done;

  lpht_ram #(
    .WIDTH(lpht_pkg::KEY_W),
    .DEPTH(lpht_pkg::SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.finish && do_write),
    .waddr_i(idx_q),
    .wdata_i({tail_q, head_q}),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
        status_q[i] <= lpht_pkg::ST_FREE;
      end
    end else if (cmd_i.finish) begin
      if (do_write) begin
        status_q[idx_q] <= lpht_pkg::ST_OCCUPIED;
      end else if (do_remove) begin
        status_q[idx_q] <= lpht_pkg::ST_REMOVED;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      head_q <= key_head_i;
      tail_q <= key_tail_i;
      sum_q  <= sum_in;
      prod_q <= lpht_pkg::PROD_W'(sum_in) * lpht_pkg::PROD_W'(lpht_pkg::RECIP_V);
    end
    if (cmd_i.finish) begin
      code_q <= code;
      slot_q <= slot;
    end
  end

  assign result_code_o = code_q;
  assign slot_index_o  = slot_q;

endmodule

### rtl/linear_probe_hash_table.sv
// Top level of the linear probing hash table of nine-byte keys.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp.
//
// Usage:
//   Input channel s_axis: one request per item. tuser carries the request
//   kind (insert, remove, look up), tdata the key, nine bytes.
//   Output channel m_axis: exactly one result per request, in order. tuser
//   carries the result code, tdata the slot index.
//   A request is hashed, then probes one slot per cycle from its home
//   slot, limited by the single read port of the key RAM; it stops at a
//   usable slot, a match, a free slot, or after all slots. One request is
//   handled at a time: the block takes no new item until the last one has
//   finished its probes and handed its result to the output register.
//   The result sits in an output register: a new request is accepted while
//   it waits. If the receiver stalls, the next request holds in its last
//   probe until the output register frees up.
//   Reset clears every slot to free and empties the output register; the
//   block is ready for an item as soon as reset is released.
module linear_probe_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // key_head [63:0], key_tail [71:64]
  input  logic [1:0]  s_axis_tuser_i,   // req_type [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // slot_index [2:0], zero [7:3]
  output logic [2:0]  m_axis_tuser_o    // result_code [2:0]
);

  lpht_pkg::lpht_cmd_t              cmd;
  lpht_pkg::lpht_sts_t              sts;
  logic [lpht_pkg::IDX_OUT_W-1:0]   slot_index;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lpht_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (s_axis_tuser_i),
    .key_head_i   (s_axis_tdata_i[63:0]),
    .key_tail_i   (s_axis_tdata_i[71:64]),
    .result_code_o(m_axis_tuser_o),
    .slot_index_o (slot_index)
  );

  assign m_axis_tdata_o = {{(lpht_pkg::OUT_DATA_W - lpht_pkg::IDX_OUT_W){1'b0}}, slot_index};

endmodule

### rtl/lpht_chk.sv
// Port checker of the hash table and its bind to the top level.
// Depends on lpht_pkg and linear_probe_hash_table_defines.svh.
`include "linear_probe_hash_table_defines.svh"

module lpht_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [71:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  `LPHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")
  `LPHT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "item accepted while busy")
  `LPHT_ASSERT_NOW(a_code_range, m_axis_tvalid_o, m_axis_tuser_o <= lpht_pkg::RC_FOUND, "result code out of range")
  `LPHT_ASSERT_NOW(a_slot_zero, m_axis_tvalid_o && (m_axis_tuser_o == lpht_pkg::RC_FULL || m_axis_tuser_o == lpht_pkg::RC_NOT_FOUND), m_axis_tdata_o == 8'd0, "slot index set without a slot")

endmodule

bind linear_probe_hash_table lpht_chk u_chk (.*);
